@@ hdl/ccsi_pkg.sv @@
package ccsi_pkg;

    localparam int unsigned NUM_CELLS = 4;
    localparam int unsigned NUM_CHANNELS = 4;
    localparam int unsigned READING_W = 16;
    localparam int unsigned FAULT_W = 4 * NUM_CELLS;
    localparam int unsigned IN_DATA_W = 136;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned CFG_INDEX_W = 2;

    // register reset values
    localparam logic signed [READING_W-1:0] TEMP_LOW_RESET = 16'sd10;
    localparam logic signed [READING_W-1:0] TEMP_HIGH_RESET = 16'sd35;
    localparam logic [READING_W-1:0] VOLT_LOW_RESET = 16'd2400;
    localparam logic [READING_W-1:0] VOLT_HIGH_RESET = 16'd4300;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLT_LOW = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLT_HIGH = 2'd3;

    // fault kinds inside one cell nibble
    localparam int unsigned FAULT_UNDER_TEMP = 0;
    localparam int unsigned FAULT_OVER_TEMP = 1;
    localparam int unsigned FAULT_UNDER_VOLT = 2;
    localparam int unsigned FAULT_OVER_VOLT = 3;

    // channel positions in the mask
    localparam int unsigned CH_CHARGE_A = 0;
    localparam int unsigned CH_CHARGE_B = 1;
    localparam int unsigned CH_DISCHARGE_A = 2;
    localparam int unsigned CH_DISCHARGE_B = 3;

    typedef enum logic [1:0] {
        CMD_SET_DIR = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_CHECK   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic signed [READING_W-1:0] temp_low;
        logic signed [READING_W-1:0] temp_high;
        logic [READING_W-1:0]        volt_low;
        logic [READING_W-1:0]        volt_high;
    } limits_t;

    typedef struct packed {
        cmd_t                                       command;
        logic                                       new_direction_a;
        logic                                       new_direction_b;
        logic [NUM_CHANNELS-1:0]                    channel_mask;
        logic [NUM_CELLS-1:0][READING_W-1:0]        cell_temp;
        logic [NUM_CELLS-1:0][READING_W-1:0]        cell_voltage;
    } item_t;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0] enables;
        logic                    direction_a;
        logic                    direction_b;
    } ctrl_state_t;

    typedef struct packed {
        ctrl_state_t        state;
        logic [FAULT_W-1:0] fault_bits;
    } result_t;

    // fault nibble of one cell against the windows
    function automatic logic [3:0] cell_faults(
        input logic [READING_W-1:0] temp,
        input logic [READING_W-1:0] volt,
        input limits_t              lim
    );
        logic [3:0] f;
        f = '0;
        f[FAULT_UNDER_TEMP] = $signed(temp) < lim.temp_low;
        f[FAULT_OVER_TEMP]  = $signed(temp) > lim.temp_high;
        f[FAULT_UNDER_VOLT] = volt < lim.volt_low;
        f[FAULT_OVER_VOLT]  = volt > lim.volt_high;
        return f;
    endfunction

endpackage

@@ hdl/ccsi_cfg_regs.sv @@
module ccsi_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [ccsi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ccsi_pkg::READING_W-1:0]   cfg_data,
    output ccsi_pkg::limits_t            limits
);
    import ccsi_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;

    // register write decode
    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEMP_LOW:  limits_next.temp_low = $signed(cfg_data);
                REG_TEMP_HIGH: limits_next.temp_high = $signed(cfg_data);
                REG_VOLT_LOW:  limits_next.volt_low = cfg_data;
                REG_VOLT_HIGH: limits_next.volt_high = cfg_data;
                default:       limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.temp_low <= TEMP_LOW_RESET;
            limits_reg.temp_high <= TEMP_HIGH_RESET;
            limits_reg.volt_low <= VOLT_LOW_RESET;
            limits_reg.volt_high <= VOLT_HIGH_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

@@ hdl/ccsi_core.sv @@
module ccsi_core (
    input  ccsi_pkg::item_t       item,
    input  ccsi_pkg::ctrl_state_t state,
    input  ccsi_pkg::limits_t     limits,
    output ccsi_pkg::result_t     result
);
    import ccsi_pkg::*;

    logic [NUM_CELLS-1:0][3:0]  faults_of_cell;
    logic [NUM_CHANNELS-1:0][1:0] cell_of_ch;
    logic [NUM_CELLS-1:0][1:0]  ch_of_cell;
    logic [NUM_CHANNELS-1:0]    ch_ok;
    logic [NUM_CHANNELS-1:0]    ch_bad;
    logic [NUM_CHANNELS-1:0]    drop_mask;
    logic                       da;
    logic                       db;

    assign da = state.direction_a;
    assign db = state.direction_b;

    // window compares, one per cell
    always_comb
    begin
        for (int c = 0; c < NUM_CELLS; c++)
        begin
            faults_of_cell[c] = cell_faults(item.cell_temp[c], item.cell_voltage[c], limits);
        end
    end

    // channel to cell mapping under the current directions
    always_comb
    begin
        cell_of_ch[CH_CHARGE_A]    = {1'b0, da};
        cell_of_ch[CH_CHARGE_B]    = {1'b1, db};
        cell_of_ch[CH_DISCHARGE_A] = {1'b0, ~da};
        cell_of_ch[CH_DISCHARGE_B] = {1'b1, ~db};
        ch_of_cell[0] = da ? 2'(CH_DISCHARGE_A) : 2'(CH_CHARGE_A);
        ch_of_cell[1] = da ? 2'(CH_CHARGE_A) : 2'(CH_DISCHARGE_A);
        ch_of_cell[2] = db ? 2'(CH_DISCHARGE_B) : 2'(CH_CHARGE_B);
        ch_of_cell[3] = db ? 2'(CH_CHARGE_B) : 2'(CH_DISCHARGE_B);
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            ch_ok[ch]  = faults_of_cell[cell_of_ch[ch]] == 4'd0;
            ch_bad[ch] = state.enables[ch] & ~ch_ok[ch];
        end
    end

    // pairs whose direction changes lose both enables
    always_comb
    begin
        drop_mask = '0;
        if (item.new_direction_a != da)
        begin
            drop_mask[CH_CHARGE_A] = 1'b1;
            drop_mask[CH_DISCHARGE_A] = 1'b1;
        end
        if (item.new_direction_b != db)
        begin
            drop_mask[CH_CHARGE_B] = 1'b1;
            drop_mask[CH_DISCHARGE_B] = 1'b1;
        end
    end

    // command decode
    always_comb
    begin
        result.state = state;
        result.fault_bits = '0;
        unique case (item.command)
            CMD_SET_DIR:
            begin
                result.state.enables = state.enables & ~drop_mask;
                result.state.direction_a = item.new_direction_a;
                result.state.direction_b = item.new_direction_b;
            end
            CMD_ENABLE:
            begin
                result.state.enables = state.enables | (item.channel_mask & ch_ok);
            end
            CMD_DISABLE:
            begin
                result.state.enables = state.enables & ~item.channel_mask;
            end
            CMD_CHECK:
            begin
                result.state.enables = state.enables & ~ch_bad;
                for (int c = 0; c < NUM_CELLS; c++)
                begin
                    result.fault_bits[4*c +: 4] =
                        ch_bad[ch_of_cell[c]] ? faults_of_cell[c] : 4'd0;
                end
            end
            default:
            begin
                result.state = state;
            end
        endcase
    end

endmodule

@@ hdl/cell_charge_safety_interlock_top.sv @@
// Safety interlock for two cell pairs with charge/discharge enables.
// Slave stream s_*: one command request per beat (set directions, enable
// mask, disable mask, safety check) with the latest readings of four cells.
// Master stream m_*: one result per request with the enables and directions
// after the command and, for a check, the fault bits at 4*cell+kind.
// Config channel cfg_*: writes the four window limits; always ready.
// A request accepted into the input register passes through the core into
// the output register once that register is free or being read, and then
// m_tvalid rises. Throughput: one request per cycle unless the receiver
// stalls; the window compares and the enable update form one combinational
// stage between the two registers.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more request before s_tready drops.
// Reset: enables cleared, both directions zero, limits back to 10/35 for
// temperature and 2400/4300 for voltage, both registers empty.
module cell_charge_safety_interlock_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // command, new_direction_a, new_direction_b, channel_mask,
    // cell0..3_temp, cell0..3_voltage
    input  logic [ccsi_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // enables_now, direction_a_now, direction_b_now, fault_bits, 2 zero bits
    output logic [ccsi_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ccsi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ccsi_pkg::READING_W-1:0]      cfg_data
);
    import ccsi_pkg::*;

    item_t       item_in;
    item_t       item_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result;
    ctrl_state_t state_reg;
    limits_t     limits;
    logic        advance;

    assign cfg_ready = 1'b1;

    ccsi_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    // unpack request beat
    always_comb
    begin
        item_in.command = cmd_t'(s_tdata[1:0]);
        item_in.new_direction_a = s_tdata[2];
        item_in.new_direction_b = s_tdata[3];
        item_in.channel_mask = s_tdata[7:4];
        for (int c = 0; c < NUM_CELLS; c++)
        begin
            item_in.cell_temp[c] = s_tdata[8 + READING_W*c +: READING_W];
            item_in.cell_voltage[c] = s_tdata[8 + READING_W*(NUM_CELLS+c) +: READING_W];
        end
    end

    // handshake between the two registers
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ccsi_core u_core (
        .item   (item_reg),
        .state  (state_reg),
        .limits (limits),
        .result (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
    end

    // interlock state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= result.state;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, out_reg.fault_bits, out_reg.state.direction_b,
                      out_reg.state.direction_a, out_reg.state.enables};

    // a disable request leaves none of its channels on
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.command == CMD_DISABLE
        |=> (state_reg.enables & $past(item_reg.channel_mask)) == 4'd0)
    else $error("disable request left a masked channel enabled");

    // only a check reports faults
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.command != CMD_CHECK |=> out_reg.fault_bits == '0)
    else $error("fault bits set by a non-check request");

    // a check never turns a channel on
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.command == CMD_CHECK
        |=> (state_reg.enables & ~$past(state_reg.enables)) == 4'd0)
    else $error("check request enabled a channel");

    // a held request is not dropped while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
    else $error("stalled request lost from the input register");

endmodule
